// ===== src/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SMX_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the following cycle
`define SMX_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/smx_pkg.sv =====
// types and constants of the stack machine executor
package smx_pkg;

  localparam int DATA_W      = 32;
  localparam int CNT_W       = $clog2(DATA_W);
  localparam int FUNC_W      = 4;
  localparam int STATUS_W    = 3;
  localparam int DEPTH_W     = 7;
  localparam int STATUS_LSB  = DATA_W;
  localparam int DEPTH_LSB   = STATUS_LSB + STATUS_W;
  localparam int OUT_USED_W  = DEPTH_LSB + DEPTH_W;
  localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;

  typedef enum logic [FUNC_W-1:0] {
    OP_PUSH = 4'd0,
    OP_HALT = 4'd1,
    OP_ADD  = 4'd2,
    OP_SUB  = 4'd3,
    OP_MUL  = 4'd4,
    OP_DIV  = 4'd5,
    OP_OUT  = 4'd6,
    OP_DUMP = 4'd7
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_HALTED  = 3'd1,
    ST_UNDER   = 3'd2,
    ST_OVER    = 3'd3,
    ST_DIVZERO = 3'd4,
    ST_INVALID = 3'd5
  } status_t;

  typedef struct packed {
    logic start;
    op_t  op;
  } alu_req_t;

endpackage

// ===== src/smx_ram.sv =====
// generic single-write, single-read ram with registered read data
module smx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/smx_alu.sv =====
// shared arithmetic unit: add, subtract, multiply and a bit-serial signed divider
module smx_alu (
  input  logic                     clk,
  input  logic                     rst,
  input  smx_pkg::alu_req_t        req,
  input  logic [smx_pkg::DATA_W-1:0] top,
  input  logic [smx_pkg::DATA_W-1:0] second,
  output logic                     done,
  output logic [smx_pkg::DATA_W-1:0] result
);
  import smx_pkg::*;

  typedef enum logic [1:0] {A_IDLE, A_DIV, A_FIX, A_DONE} alu_state_t;

  alu_state_t        alu_state;
  logic [DATA_W-1:0] quo;
  logic [DATA_W:0]   rem;
  logic [DATA_W-1:0] dmag;
  logic              neg;
  logic [CNT_W-1:0]  cnt;

  logic [DATA_W-1:0] nmag_in;
  logic [DATA_W-1:0] dmag_in;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   diff;

  assign nmag_in = second[DATA_W-1] ? (~second + 1'b1) : second;
  assign dmag_in = top[DATA_W-1] ? (~top + 1'b1) : top;
  assign rem_sh  = {rem[DATA_W-1:0], quo[DATA_W-1]};
  assign diff    = rem_sh - {1'b0, dmag};
  assign done    = (alu_state == A_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      alu_state <= A_IDLE;
    end else begin
      case (alu_state)
        A_IDLE: begin
          if (req.start) begin
            case (req.op)
              OP_ADD: begin
                result    <= top + second;
                alu_state <= A_DONE;
              end
              OP_SUB: begin
                result    <= top - second;
                alu_state <= A_DONE;
              end
              OP_MUL: begin
                result    <= DATA_W'(top * second);
                alu_state <= A_DONE;
              end
              OP_DIV: begin
                // second / top on magnitudes, sign fixed at the end
                quo       <= nmag_in;
                rem       <= '0;
                dmag      <= dmag_in;
                neg       <= second[DATA_W-1] ^ top[DATA_W-1];
                cnt       <= CNT_W'(DATA_W - 1);
                alu_state <= A_DIV;
              end
              default: begin
                result    <= '0;
                alu_state <= A_DONE;
              end
            endcase
          end
        end
        A_DIV: begin
          if (!diff[DATA_W]) begin
            rem <= diff;
            quo <= {quo[DATA_W-2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[DATA_W-2:0], 1'b0};
          end
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            alu_state <= A_FIX;
          end
        end
        A_FIX: begin
          result    <= neg ? (~quo + 1'b1) : quo;
          alu_state <= A_DONE;
        end
        A_DONE: begin
          alu_state <= A_IDLE;
        end
        default: begin
          alu_state <= A_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/stack_machine_executor.sv =====
// Stack machine executor: runs one instruction per input request against a stack held in a
// single-port-read ram of STACK_DEPTH words, and returns one result per instruction. The block
// takes one instruction at a time. Push, halt, dump, ignored and rejected instructions go
// straight to the result; a divide by zero is only seen after the two ram reads. Out does one
// ram read; add, sub and mul do two ram reads through the one read port, then one pass of the
// shared unit; div runs through the divider, which resolves one quotient bit a cycle. A result
// held on the output because the downstream side is stalling does not stop the next instruction
// being taken; a second one waits for it.
// Stack entries are never cleared: only words already pushed are read.
module stack_machine_executor #(
  parameter int STACK_DEPTH = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [smx_pkg::DATA_W-1:0]      s_tdata,   // immediate [31:0]
  input  logic [smx_pkg::FUNC_W-1:0]      s_tuser,   // func [3:0]
  input  logic                            s_tlast,   // last_word
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [smx_pkg::OUT_TDATA_W-1:0] m_tdata,   // out_value [31:0], status [34:32],
                                                     // depth [41:35], zero [47:42]
  output logic                            m_tuser    // out_valid
);
  import smx_pkg::*;

  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_RD_TOP, S_RD_SEC, S_ALU, S_RD_OUT, S_FINISH
  } state_t;

  state_t            state;
  logic [SPW-1:0]    sp;
  logic              halted;
  op_t               op_q;
  logic              last_q;
  logic [DATA_W-1:0] top_q;
  logic [DATA_W-1:0] res_value;
  logic              res_valid;
  status_t           res_status;
  logic [DATA_W-1:0] out_value;
  logic              out_valid;
  status_t           out_status;
  logic [DEPTH_W-1:0] out_depth;

  logic              accept;
  op_t               op_in;
  logic [SPW-1:0]    sp_m1;
  logic [SPW-1:0]    sp_m2;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_rdata;
  alu_req_t          alu_req;
  logic              alu_done;
  logic [DATA_W-1:0] alu_result;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign op_in    = op_t'(s_tuser);
  assign sp_m1    = sp - SPW'(1);
  assign sp_m2    = sp - SPW'(2);
  assign m_tdata  = {(OUT_TDATA_W - OUT_USED_W)'(0), out_depth, out_status, out_value};
  assign m_tuser  = out_valid;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = sp[AW-1:0];
    ram_wdata = s_tdata;
    ram_raddr = sp_m1[AW-1:0];
    alu_req   = '{start: 1'b0, op: op_q};
    case (state)
      S_IDLE: begin
        if (accept && !halted && op_in == OP_PUSH && sp != SPW'(STACK_DEPTH)) begin
          ram_we = 1'b1;
        end
      end
      S_RD_TOP: begin
        ram_raddr = sp_m2[AW-1:0];
      end
      S_RD_SEC: begin
        alu_req.start = !(op_q == OP_DIV && top_q == '0);
      end
      S_ALU: begin
        // result replaces second, top is dropped
        ram_we    = alu_done;
        ram_waddr = sp_m2[AW-1:0];
        ram_wdata = alu_result;
      end
      default: begin
      end
    endcase
  end

  smx_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  smx_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .req    (alu_req),
    .top    (top_q),
    .second (ram_rdata),
    .done   (alu_done),
    .result (alu_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      sp       <= '0;
      halted   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // in S_FINISH the output register is handled below
      if (m_tready && state != S_FINISH) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            op_q       <= op_in;
            last_q     <= s_tlast;
            res_value  <= '0;
            res_valid  <= 1'b0;
            res_status <= ST_OK;
            state      <= S_FINISH;
            if (halted) begin
              res_status <= ST_HALTED;
            end else begin
              case (op_in)
                OP_PUSH: begin
                  if (sp == SPW'(STACK_DEPTH)) begin
                    res_status <= ST_OVER;
                  end else begin
                    sp <= sp + SPW'(1);
                  end
                end
                OP_HALT: begin
                  halted <= 1'b1;
                end
                OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                  if (sp < SPW'(2)) begin
                    res_status <= ST_UNDER;
                  end else begin
                    state <= S_RD_TOP;
                  end
                end
                OP_OUT: begin
                  if (sp == '0) begin
                    res_status <= ST_UNDER;
                  end else begin
                    state <= S_RD_OUT;
                  end
                end
                OP_DUMP: begin
                end
                default: begin
                  res_status <= ST_INVALID;
                end
              endcase
            end
          end
        end
        S_RD_TOP: begin
          top_q <= ram_rdata;
          state <= S_RD_SEC;
        end
        S_RD_SEC: begin
          if (op_q == OP_DIV && top_q == '0) begin
            res_status <= ST_DIVZERO;
            state      <= S_FINISH;
          end else begin
            state <= S_ALU;
          end
        end
        S_ALU: begin
          if (alu_done) begin
            sp    <= sp_m1;
            state <= S_FINISH;
          end
        end
        S_RD_OUT: begin
          res_value <= ram_rdata;
          res_valid <= 1'b1;
          sp        <= sp_m1;
          state     <= S_FINISH;
        end
        S_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid   <= 1'b1;
            out_value  <= res_value;
            out_valid  <= res_valid;
            out_status <= res_status;
            // depth is reported before the end-of-program clear
            out_depth  <= DEPTH_W'(sp);
            if (last_q) begin
              sp     <= '0;
              halted <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/smx_checker.sv =====
// port-level checks on the stack machine executor and their bind
`include "assert_macros.svh"

module smx_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [smx_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic                            m_tuser
);
  import smx_pkg::*;

  // a stalled result holds
  `SMX_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

  // one instruction at a time
  `SMX_ASSERT_NEXT(a_busy_after_req, clk, rst, s_tvalid && s_tready, !s_tready, "request taken while busy")

  // an emitted value only comes with a good status
  `SMX_ASSERT_SAME(a_emit_ok, clk, rst, m_tvalid && m_tuser, m_tdata[STATUS_LSB +: STATUS_W] == ST_OK, "value emitted with error status")

  // no emitted value means a zero value field
  `SMX_ASSERT_SAME(a_value_zero, clk, rst, m_tvalid && !m_tuser, m_tdata[DATA_W-1:0] == '0, "value field not zero")

endmodule

bind stack_machine_executor smx_checker u_smx_checker (.*);
